// ===== rtl/core/fila_pkg.sv =====
// Shared types and constants of the free index list allocator.
`timescale 1ns / 1ps

package fila_pkg;

   localparam int CAPACITY_W        = 9;
   localparam int INDEX_W           = 8;
   localparam int STATUS_W          = 2;
   localparam int MAX_SLOTS_DEFAULT = 256;
   localparam int CAPACITY_RESET    = 256;

   typedef enum logic [0:0] {
      FUNC_ALLOC   = 1'b0,
      FUNC_RELEASE = 1'b1
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_RANGE     = 2'd2,
      STATUS_NOT_TAKEN = 2'd3
   } status_type;

endpackage

// ===== rtl/core/free_index_list_allocator.sv =====
// Top level of the free index list allocator: head register, link memory and result register.
//
//   Channel   Ports                                   Direction  Handshake
//   request   start, busy, req_func, req_item_index   in         start high, busy low
//   response  rsp_valid, rsp_status, rsp_granted_index out       one-cycle strobe
//   config    csr_wr_en, csr_capacity                 in         write enable, no wait
//
// A transaction is accepted in every cycle; the input register and the registered read of
// the link memory load at the accepting edge, and the result register, which drives the
// response, loads in the cycle after.
// Reset needs no clearing pass: a fill count marks which link
// entries have been written since the last rebuild, the rest read as index plus one.
// A capacity write rebuilds the list at once in the same way.
// The receiver cannot stall; busy stays low.
`timescale 1ns / 1ps

module free_index_list_allocator #(
   parameter int MAX_SLOTS = fila_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_func,
   input  logic [fila_pkg::INDEX_W-1:0]      req_item_index,
   output logic                              rsp_valid,
   output logic [fila_pkg::STATUS_W-1:0]     rsp_status,
   output logic [fila_pkg::INDEX_W-1:0]      rsp_granted_index,
   input  logic                              csr_wr_en,
   input  logic [fila_pkg::CAPACITY_W-1:0]   csr_capacity
);

   localparam int AW = $clog2(MAX_SLOTS);
   localparam int HW = $clog2(MAX_SLOTS + 1);
   localparam int LW = $clog2(MAX_SLOTS + 2);
   localparam int CapReset = (fila_pkg::CAPACITY_RESET > MAX_SLOTS) ?
                             MAX_SLOTS : fila_pkg::CAPACITY_RESET;

   logic [LW-1:0] link_mem [0:MAX_SLOTS-1];

   logic [HW-1:0] cap_ff, cap_in;
   logic [HW-1:0] head_ff, head_in;
   logic [HW-1:0] fill_ff, fill_in;

   logic                           x_valid_ff;
   fila_pkg::func_type             x_func_ff;
   logic [fila_pkg::INDEX_W-1:0]   x_index_ff;

   logic [LW-1:0] rd_head_link_ff;
   logic [LW-1:0] rd_item_link_ff;

   logic                           rsp_valid_ff;
   fila_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [fila_pkg::INDEX_W-1:0]   rsp_granted_ff, rsp_granted_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [LW-1:0] mem_wdata;
   logic [AW-1:0] raddr_head;
   logic [AW-1:0] raddr_item;

   logic [LW-1:0] taken_mark;
   logic [LW-1:0] head_link;
   logic [LW-1:0] item_link;
   logic [HW-1:0] cap_wr;

   assign busy = 1'b0;

   assign taken_mark = LW'(LW'(cap_ff) + 1'b1);

   assign head_link = (head_ff < fill_ff) ? rd_head_link_ff : LW'(LW'(head_ff) + 1'b1);
   assign item_link = (32'(x_index_ff) < 32'(fill_ff)) ?
                      rd_item_link_ff : LW'(LW'(x_index_ff) + 1'b1);

   always_comb begin
      if (csr_capacity == '0) begin
         cap_wr = HW'(1);
      end else if (32'(csr_capacity) > 32'(MAX_SLOTS)) begin
         cap_wr = HW'(MAX_SLOTS);
      end else begin
         cap_wr = HW'(csr_capacity);
      end
   end

   always_comb begin
      cap_in         = cap_ff;
      head_in        = head_ff;
      fill_in        = fill_ff;
      mem_we         = 1'b0;
      mem_waddr      = AW'(head_ff);
      mem_wdata      = taken_mark;
      rsp_status_in  = fila_pkg::STATUS_OK;
      rsp_granted_in = '0;
      if (x_valid_ff) begin
         unique case (x_func_ff)
            fila_pkg::FUNC_ALLOC: begin
               if (head_ff >= cap_ff) begin
                  rsp_status_in = fila_pkg::STATUS_EMPTY;
               end else begin
                  mem_we         = 1'b1;
                  mem_waddr      = AW'(head_ff);
                  mem_wdata      = taken_mark;
                  head_in        = HW'(head_link);
                  rsp_granted_in = fila_pkg::INDEX_W'(head_ff);
                  if (head_ff >= fill_ff) begin
                     fill_in = HW'(head_ff + 1'b1);
                  end
               end
            end
            fila_pkg::FUNC_RELEASE: begin
               if (32'(x_index_ff) >= 32'(cap_ff)) begin
                  rsp_status_in = fila_pkg::STATUS_RANGE;
               end else if (item_link != taken_mark) begin
                  rsp_status_in = fila_pkg::STATUS_NOT_TAKEN;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(x_index_ff);
                  mem_wdata = LW'(head_ff);
                  head_in   = HW'(x_index_ff);
               end
            end
            default: begin
            end
         endcase
      end
      if (csr_wr_en) begin
         cap_in  = cap_wr;
         head_in = '0;
         fill_in = '0;
      end
   end

   assign raddr_head = AW'(head_in);
   assign raddr_item = AW'(req_item_index);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_we && (mem_waddr == raddr_head)) begin
         rd_head_link_ff <= mem_wdata;
      end else begin
         rd_head_link_ff <= link_mem[raddr_head];
      end
      if (mem_we && (mem_waddr == raddr_item)) begin
         rd_item_link_ff <= mem_wdata;
      end else begin
         rd_item_link_ff <= link_mem[raddr_item];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= HW'(CapReset);
         head_ff      <= '0;
         fill_ff      <= '0;
         x_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         x_valid_ff   <= start && !busy;
         rsp_valid_ff <= x_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_func_ff      <= fila_pkg::func_type'(req_func);
      x_index_ff     <= req_item_index;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_granted_ff;

   assert property (@(posedge clock) disable iff (reset) head_ff <= fill_ff)
      else $error("Free list head lies beyond the written part of the link memory.");

   assert property (@(posedge clock) disable iff (reset) fill_ff <= cap_ff)
      else $error("Fill count exceeds the capacity.");

   assert property (@(posedge clock) disable iff (reset) x_valid_ff |=> rsp_valid)
      else $error("Accepted transaction produced no response.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != fila_pkg::STATUS_OK) |-> rsp_granted_index == '0)
      else $error("Failed transaction returned a non-zero index.");

   assert property (@(posedge clock) disable iff (reset)
      $past(csr_wr_en) |-> (head_ff == '0) && (fill_ff == '0))
      else $error("Capacity write did not rebuild the free list.");

endmodule

// ===== tb/tb_free_index_list_allocator.sv =====
// Self-checking testbench of the free index list allocator with a response predictor.
`timescale 1ns / 1ps

module tb_free_index_list_allocator;

   localparam int SLOTS       = fila_pkg::MAX_SLOTS_DEFAULT;
   localparam int STALL_LIMIT = 2000;
   localparam int CAP_W       = fila_pkg::CAPACITY_W;
   localparam int IDX_W       = fila_pkg::INDEX_W;
   localparam int ST_W        = fila_pkg::STATUS_W;

   typedef struct packed {
      fila_pkg::status_type  status;
      logic [IDX_W-1:0]      granted;
   } alloc_result_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_func;
   logic [IDX_W-1:0]       req_item_index;
   logic                   rsp_valid;
   logic [ST_W-1:0]        rsp_status;
   logic [IDX_W-1:0]       rsp_granted_index;
   logic                   csr_wr_en;
   logic [CAP_W-1:0]       csr_capacity;

   logic [CAP_W-1:0]       slot_limit;
   logic [CAP_W-1:0]       free_head;
   logic [CAP_W-1:0]       next_free [0:SLOTS];
   logic [IDX_W-1:0]       held_indices [$];
   alloc_result_type       pending_results [$];
   int                     mismatches = 0;
   int                     quiet_cycles = 0;

   free_index_list_allocator u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_item_index    (req_item_index),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .csr_wr_en         (csr_wr_en),
      .csr_capacity      (csr_capacity)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void rebuild_free_list(input logic [CAP_W-1:0] value);
      logic [CAP_W-1:0] limited;
      limited = value;
      if (limited < 1) limited = 1;
      if (limited > SLOTS) limited = SLOTS;
      slot_limit = limited;
      for (int i = 0; i <= SLOTS; i++) next_free[i] = CAP_W'(i + 1);
      free_head = '0;
      held_indices.delete();
   endfunction

   function automatic void predict_request(input fila_pkg::func_type f,
                                           input logic [IDX_W-1:0] idx,
                                           output alloc_result_type res);
      logic [CAP_W-1:0] taken_mark;
      logic [CAP_W-1:0] popped;
      taken_mark  = slot_limit + 1'b1;
      res.granted = '0;
      if (f == fila_pkg::FUNC_ALLOC) begin
         if (free_head >= slot_limit) begin
            res.status = fila_pkg::STATUS_EMPTY;
         end else begin
            popped            = free_head;
            free_head         = next_free[popped];
            next_free[popped] = taken_mark;
            res.granted       = popped[IDX_W-1:0];
            res.status        = fila_pkg::STATUS_OK;
            held_indices.push_back(popped[IDX_W-1:0]);
         end
      end else if (idx >= slot_limit) begin
         res.status = fila_pkg::STATUS_RANGE;
      end else if (next_free[idx] != taken_mark) begin
         res.status = fila_pkg::STATUS_NOT_TAKEN;
      end else begin
         next_free[idx] = free_head;
         free_head      = {1'b0, idx};
         res.status     = fila_pkg::STATUS_OK;
         for (int i = 0; i < held_indices.size(); i++) begin
            if (held_indices[i] == idx) begin
               held_indices.delete(i);
               break;
            end
         end
      end
   endfunction

   task automatic issue_request(input fila_pkg::func_type f, input logic [IDX_W-1:0] idx,
                                input int gap = 0);
      alloc_result_type res;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_func       <= f;
      req_item_index <= idx;
      do @(posedge clock); while (busy);
      predict_request(f, idx, res);
      pending_results.push_back(res);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      wait_for_drain();
      repeat (3) @(posedge clock);
      csr_wr_en    <= 1'b1;
      csr_capacity <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      rebuild_free_list(value);
   endtask

   function automatic int draw_gap(input int idle_pct);
      int gap;
      gap = 0;
      while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
      return gap;
   endfunction

   task automatic test_alloc_release_basics();
      issue_request(fila_pkg::FUNC_ALLOC, 8'hFF);
      issue_request(fila_pkg::FUNC_ALLOC, 8'h00);
      issue_request(fila_pkg::FUNC_RELEASE, 8'd1);
      issue_request(fila_pkg::FUNC_RELEASE, 8'd1);
      issue_request(fila_pkg::FUNC_RELEASE, 8'd255);
      issue_request(fila_pkg::FUNC_RELEASE, 8'd0);
      issue_request(fila_pkg::FUNC_ALLOC, 8'hAA);
      issue_request(fila_pkg::FUNC_ALLOC, 8'h55);
   endtask

   task automatic test_capacity_extremes();
      write_capacity(9'd0);
      issue_request(fila_pkg::FUNC_ALLOC, 8'd0);
      issue_request(fila_pkg::FUNC_ALLOC, 8'd0);
      issue_request(fila_pkg::FUNC_RELEASE, 8'd1);
      issue_request(fila_pkg::FUNC_RELEASE, 8'd255);
      issue_request(fila_pkg::FUNC_RELEASE, 8'd0);
      issue_request(fila_pkg::FUNC_RELEASE, 8'd0);
      write_capacity(9'd511);
      issue_request(fila_pkg::FUNC_RELEASE, 8'd255);
      issue_request(fila_pkg::FUNC_ALLOC, 8'd0);
      write_capacity(9'd257);
      issue_request(fila_pkg::FUNC_ALLOC, 8'd0);
      issue_request(fila_pkg::FUNC_RELEASE, 8'd0);
   endtask

   task automatic test_rebuild_frees_all();
      write_capacity(9'd3);
      issue_request(fila_pkg::FUNC_ALLOC, 8'd0);
      issue_request(fila_pkg::FUNC_ALLOC, 8'd0);
      write_capacity(9'd3);
      issue_request(fila_pkg::FUNC_RELEASE, 8'd0);
      issue_request(fila_pkg::FUNC_ALLOC, 8'd0);
   endtask

   // Mostly allocations and releases of held indices, with stray releases mixed in.
   task automatic run_traffic(input logic [CAP_W-1:0] cap, input int idle_pct,
                              input int count);
      int pick;
      write_capacity(cap);
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) wait_for_drain();
         pick = $urandom_range(99);
         if (pick < 45) begin
            issue_request(fila_pkg::FUNC_ALLOC, IDX_W'($urandom), draw_gap(idle_pct));
         end else if (pick < 85 && held_indices.size() != 0) begin
            issue_request(fila_pkg::FUNC_RELEASE,
                          held_indices[$urandom_range(held_indices.size() - 1)],
                          draw_gap(idle_pct));
         end else begin
            issue_request(fila_pkg::FUNC_RELEASE, IDX_W'($urandom), draw_gap(idle_pct));
         end
      end
   endtask

   task automatic test_random_traffic();
      run_traffic(9'd256, 0, 140);
      run_traffic(9'd7, 79, 100);
      run_traffic(9'd1, 0, 40);
      run_traffic(9'd130, 34, 150);
      run_traffic(9'd511, 79, 100);
      run_traffic(9'd2, 34, 60);
      run_traffic(9'd40, 0, 60);
   endtask

   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response: status %0d, granted_index %0d",
                   rsp_status, rsp_granted_index);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, actual %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_granted_index !== want.granted) begin
               $error("rsp_granted_index: expected %0d, actual %0d",
                      want.granted, rsp_granted_index);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_func       <= fila_pkg::FUNC_ALLOC;
      req_item_index <= '0;
      csr_wr_en      <= 1'b0;
      csr_capacity   <= CAP_W'(fila_pkg::CAPACITY_RESET);
      rebuild_free_list(CAP_W'(fila_pkg::CAPACITY_RESET));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_alloc_release_basics();
      test_capacity_extremes();
      test_rebuild_frees_all();
      test_random_traffic();
      wait_for_drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/fila_pkg.sv
rtl/core/free_index_list_allocator.sv
tb/tb_free_index_list_allocator.sv
